// File: rtl/core/fesi_pkg.sv
// shared constants, types and stage map of the linear shape interpolation block
package fesi_pkg;

    localparam int VALUE_WIDTH     = 32;
    localparam int COORD_FRAC_BITS = 14;
    localparam int COORD_W         = 16;
    localparam int NV              = 6;
    localparam int NPYR            = 4;

    // width of the linear sums (1-w, 1-u-v, a-2u and so on)
    localparam int AW = ((COORD_FRAC_BITS + 1 > COORD_W) ? COORD_FRAC_BITS + 1 : COORD_W) + 2;
    localparam int PW = 2 * AW;
    // pyramid numerator after the divide by eight, divisor magnitude, weight width
    localparam int NW = PW - 4;
    localparam int DW = AW - 1;
    localparam int LW = NW + 1;
    localparam int MW = LW + VALUE_WIDTH;
    localparam int SW = MW + 3;
    localparam int ONE_INT = 1 << COORD_FRAC_BITS;

    // pipeline stage map
    localparam int ST_IN   = 0;
    localparam int ST_MUL  = 1;
    localparam int ST_PREP = 2;
    localparam int ST_DIV0 = 3;
    localparam int ST_SEL  = ST_DIV0 + NW;
    localparam int ST_MAC  = ST_SEL + 1;
    localparam int ST_PAIR = ST_SEL + 2;
    localparam int ST_SUM  = ST_SEL + 3;
    localparam int ST_OUT  = ST_SEL + 4;
    localparam int NST     = ST_SEL + 5;

    typedef enum logic [1:0] {
        TOPO_TET   = 2'd0,
        TOPO_PYR   = 2'd1,
        TOPO_WEDGE = 2'd2,
        TOPO_NONE  = 2'd3
    } topo_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_TOPO = 2'd1,
        ERR_APEX = 2'd2
    } err_t;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic signed [COORD_W-1:0]     coord_t;
    typedef logic signed [AW-1:0]          sum_t;
    typedef logic signed [PW-1:0]          prod_t;
    typedef logic signed [LW-1:0]          weight_t;
    typedef logic signed [MW-1:0]          mac_t;
    typedef logic [NW-1:0]                 num_t;
    typedef logic [DW-1:0]                 div_t;

    typedef struct packed {
        topo_t                topo;
        coord_t               u;
        coord_t               v;
        coord_t               w;
        value_t [NV-1:0]      vals;
        logic                 last;
    } raw_t;

    typedef struct packed {
        logic                 last;
        err_t                 err;
        topo_t                topo;
        logic [NPYR-1:0]      qneg;
        weight_t [NV-1:0]     fw;
        value_t [NV-1:0]      vals;
    } carry_t;

    typedef struct packed {
        carry_t               c;
        num_t [NPYR-1:0]      num;
        div_t                 amag;
    } prep_t;

    typedef struct packed {
        logic                 last;
        err_t                 err;
    } tag_t;

    typedef struct packed {
        logic                 mul;
        logic                 prep;
    } shape_en_t;

    typedef struct packed {
        logic                 pair;
        logic                 total;
        logic                 out;
    } merge_en_t;

endpackage

// File: rtl/core/fe_linear_shape_interpolate.sv
// top level: linear shape function interpolation pipeline for tet, pyramid and wedge
// structure: 40 pipeline stages, 32 of them the bit-per-stage pyramid weight dividers
// throughput: one transaction per cycle; bubbles close up while the output stalls,
//   in_stall rises only when every stage holds a transaction and out_stall is high
// reset: rst_n clears the stage valid flags only, data registers are not reset
module fe_linear_shape_interpolate (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       topology,
    input  fesi_pkg::coord_t coord_u,
    input  fesi_pkg::coord_t coord_v,
    input  fesi_pkg::coord_t coord_w,
    input  fesi_pkg::value_t node_value_0,
    input  fesi_pkg::value_t node_value_1,
    input  fesi_pkg::value_t node_value_2,
    input  fesi_pkg::value_t node_value_3,
    input  fesi_pkg::value_t node_value_4,
    input  fesi_pkg::value_t node_value_5,
    input  logic             last_dof,
    output logic             out_valid,
    input  logic             out_stall,
    output fesi_pkg::value_t interp_value,
    output logic [1:0]       error_code,
    output logic             last_out
);
    import fesi_pkg::*;

    logic [NST-1:0]  vld_reg, vld_next, en;
    logic            blocked;

    raw_t            raw_next, raw_reg;
    prep_t           prep;
    shape_en_t       shape_en;
    merge_en_t       merge_en;
    carry_t          cr_reg [NW];
    carry_t          cs;
    num_t            quo [NPYR];
    weight_t         wsel_next [NV];
    weight_t         wsel_reg  [NV];
    value_t [NV-1:0] vsel_reg;
    tag_t            tag_sel_reg, tag_mac_reg;
    mac_t [NV-1:0]   prod;

    // stage k loads when it is empty or some stage above it can take a step
    always_comb
    begin
        blocked = vld_reg[NST-1] && out_stall;
        for (int k = 0; k < NST; k++)
        begin
            en[k] = !blocked || (((~vld_reg) >> k) != '0);
        end
        vld_next = (en & {vld_reg[NST-2:0], in_valid}) | (~en & vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = !en[ST_IN];
    assign out_valid = vld_reg[ST_OUT];

    always_comb
    begin
        raw_next.topo = topo_t'(topology);
        raw_next.u    = coord_u;
        raw_next.v    = coord_v;
        raw_next.w    = coord_w;
        raw_next.vals = {node_value_5, node_value_4, node_value_3,
                         node_value_2, node_value_1, node_value_0};
        raw_next.last = last_dof;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_IN])
        begin
            raw_reg <= raw_next;
        end
    end

    assign shape_en.mul  = en[ST_MUL];
    assign shape_en.prep = en[ST_PREP];

    fesi_shape u_shape (
        .clk  (clk),
        .en   (shape_en),
        .raw  (raw_reg),
        .prep (prep)
    );

    for (genvar k = 0; k < NPYR; k++)
    begin : g_div
        fesi_div_lane u_div (
            .clk (clk),
            .en  (en[ST_DIV0 +: NW]),
            .num (prep.num[k]),
            .dvs (prep.amag),
            .quo (quo[k])
        );
    end

    // rest of the transaction rides alongside the divider stages
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NW; j++)
        begin
            if (en[ST_DIV0 + j])
            begin
                cr_reg[j] <= (j == 0) ? prep.c : cr_reg[(j == 0) ? 0 : j - 1];
            end
        end
    end

    always_comb
    begin
        cs = cr_reg[NW-1];
        for (int k = 0; k < NV; k++)
        begin
            wsel_next[k] = cs.fw[k];
        end
        for (int k = 0; k < NPYR; k++)
        begin
            if (cs.topo == TOPO_PYR)
            begin
                wsel_next[k] = cs.qneg[k] ? -weight_t'(quo[k]) : weight_t'(quo[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SEL])
        begin
            for (int k = 0; k < NV; k++)
            begin
                wsel_reg[k] <= wsel_next[k];
            end
            vsel_reg         <= cs.vals;
            tag_sel_reg.last <= cs.last;
            tag_sel_reg.err  <= cs.err;
        end
        if (en[ST_MAC])
        begin
            tag_mac_reg <= tag_sel_reg;
        end
    end

    for (genvar k = 0; k < NV; k++)
    begin : g_mac
        fesi_mac_lane u_mac (
            .clk  (clk),
            .en   (en[ST_MAC]),
            .wt   (wsel_reg[k]),
            .val  (vsel_reg[k]),
            .prod (prod[k])
        );
    end

    assign merge_en.pair  = en[ST_PAIR];
    assign merge_en.total = en[ST_SUM];
    assign merge_en.out   = en[ST_OUT];

    fesi_merge u_merge (
        .clk          (clk),
        .en           (merge_en),
        .prod         (prod),
        .tag          (tag_mac_reg),
        .interp_value (interp_value),
        .error_code   (error_code),
        .last_out     (last_out)
    );

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&vld_reg))
        else $error("input stalled while a stage is empty");

    a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output is free");

    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld_reg[ST_IN])
        else $error("accepted transaction lost at input stage");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error_code != ERR_NONE) |-> (interp_value == '0))
        else $error("error result with nonzero value");

endmodule

// File: rtl/core/fesi_shape.sv
// shape weight front end: linear sums, product lanes, rounding and divider operands
module fesi_shape (
    input  logic                clk,
    input  fesi_pkg::shape_en_t en,
    input  fesi_pkg::raw_t      raw,
    output fesi_pkg::prep_t     prep
);
    import fesi_pkg::*;

    function automatic weight_t rnd_shr(input prod_t x, input int sh);
        prod_t half;
        prod_t neg;
        half = prod_t'(1) <<< (sh - 1);
        neg  = prod_t'(x[PW-1]);
        // nearest, ties away from zero
        return weight_t'((x + half - neg) >>> sh);
    endfunction

    sum_t            u_s, v_s, w_s, one_s, a_s, hw_s, kk_s, t0_s;
    sum_t            pu, mu, pv, mv;
    sum_t            opa [NV];
    sum_t            opb [NV];
    prod_t           mul_next [NV];
    err_t            err_next;

    prod_t           mul_reg [NV];
    sum_t            a_reg, hw_reg, t0_reg, u_reg, v_reg, w_reg;
    topo_t           topo_reg;
    err_t            err_reg;
    logic            last_reg;
    value_t [NV-1:0] vals_reg;

    logic [PW-1:0]   nmag [NPYR];
    logic [PW:0]     nsum [NPYR];
    div_t            amag;
    prep_t           prep_next;
    prep_t           prep_reg;

    always_comb
    begin
        one_s = sum_t'(ONE_INT);
        u_s   = sum_t'($signed(raw.u));
        v_s   = sum_t'($signed(raw.v));
        w_s   = sum_t'($signed(raw.w));
        a_s   = one_s - w_s;
        hw_s  = one_s + w_s;
        kk_s  = one_s - u_s - v_s;
        t0_s  = kk_s - w_s;
        pu    = a_s - (u_s + u_s);
        mu    = a_s + (u_s + u_s);
        pv    = a_s - (v_s + v_s);
        mv    = a_s + (v_s + v_s);

        // wedge operands by default, pyramid lanes swap in their factors
        opa[0] = kk_s; opb[0] = a_s;
        opa[1] = u_s;  opb[1] = a_s;
        opa[2] = v_s;  opb[2] = a_s;
        opa[3] = kk_s; opb[3] = hw_s;
        opa[4] = u_s;  opb[4] = hw_s;
        opa[5] = v_s;  opb[5] = hw_s;
        if (raw.topo == TOPO_PYR)
        begin
            opa[0] = pu; opb[0] = pv;
            opa[1] = mu; opb[1] = pv;
            opa[2] = mu; opb[2] = mv;
            opa[3] = pu; opb[3] = mv;
        end
        for (int k = 0; k < NV; k++)
        begin
            mul_next[k] = prod_t'(opa[k]) * prod_t'(opb[k]);
        end

        if (raw.topo == TOPO_NONE)
        begin
            err_next = ERR_TOPO;
        end
        else if (raw.topo == TOPO_PYR && a_s == '0)
        begin
            err_next = ERR_APEX;
        end
        else
        begin
            err_next = ERR_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            for (int k = 0; k < NV; k++)
            begin
                mul_reg[k] <= mul_next[k];
            end
            a_reg    <= a_s;
            hw_reg   <= hw_s;
            t0_reg   <= t0_s;
            u_reg    <= u_s;
            v_reg    <= v_s;
            w_reg    <= w_s;
            topo_reg <= raw.topo;
            err_reg  <= err_next;
            last_reg <= raw.last;
            vals_reg <= raw.vals;
        end
    end

    always_comb
    begin
        amag = div_t'(a_reg[AW-1] ? -a_reg : a_reg);

        prep_next.amag   = amag;
        prep_next.c.last = last_reg;
        prep_next.c.err  = err_reg;
        prep_next.c.topo = topo_reg;
        prep_next.c.vals = vals_reg;

        // pyramid: |n|/(8|a|) rounded = floor(floor((|n| + 4|a|) / 8) / |a|)
        for (int k = 0; k < NPYR; k++)
        begin
            nmag[k] = mul_reg[k][PW-1] ? -mul_reg[k] : mul_reg[k];
            nsum[k] = {1'b0, nmag[k]} + (PW + 1)'({amag, 2'b00});
            prep_next.num[k]    = num_t'(nsum[k] >> 3);
            prep_next.c.qneg[k] = mul_reg[k][PW-1] ^ a_reg[AW-1];
        end

        for (int k = 0; k < NV; k++)
        begin
            prep_next.c.fw[k] = '0;
        end
        case (topo_reg)
            TOPO_TET:
            begin
                prep_next.c.fw[0] = weight_t'(t0_reg);
                prep_next.c.fw[1] = weight_t'(u_reg);
                prep_next.c.fw[2] = weight_t'(v_reg);
                prep_next.c.fw[3] = weight_t'(w_reg);
            end
            TOPO_PYR:
            begin
                prep_next.c.fw[4] = rnd_shr(prod_t'(hw_reg), 1);
            end
            TOPO_WEDGE:
            begin
                for (int k = 0; k < NV; k++)
                begin
                    prep_next.c.fw[k] = rnd_shr(mul_reg[k], COORD_FRAC_BITS + 1);
                end
            end
            default:
            begin
                prep_next.c.fw[0] = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.prep)
        begin
            prep_reg <= prep_next;
        end
    end

    assign prep = prep_reg;

endmodule

// File: rtl/core/fesi_div_lane.sv
// pipelined restoring divider lane, one quotient bit per stage
module fesi_div_lane (
    input  logic                    clk,
    input  logic [fesi_pkg::NW-1:0] en,
    input  fesi_pkg::num_t          num,
    input  fesi_pkg::div_t          dvs,
    output fesi_pkg::num_t          quo
);
    import fesi_pkg::*;

    div_t        rem_reg [NW];
    num_t        nq_reg  [NW];
    div_t        dv_reg  [NW];

    div_t        rem_in  [NW];
    num_t        nq_in   [NW];
    div_t        dv_in   [NW];
    logic [DW:0] trial   [NW];
    logic        ge      [NW];
    div_t        rem_nx  [NW];
    num_t        nq_nx   [NW];

    for (genvar j = 0; j < NW; j++)
    begin : g_stage
        if (j == 0)
        begin : g_first
            assign rem_in[j] = '0;
            assign nq_in[j]  = num;
            assign dv_in[j]  = dvs;
        end
        else
        begin : g_next
            assign rem_in[j] = rem_reg[j-1];
            assign nq_in[j]  = nq_reg[j-1];
            assign dv_in[j]  = dv_reg[j-1];
        end

        // numerator bits shift out the top while quotient bits enter at the bottom
        always_comb
        begin
            trial[j]  = {rem_in[j], nq_in[j][NW-1]};
            ge[j]     = trial[j] >= {1'b0, dv_in[j]};
            rem_nx[j] = ge[j] ? DW'(trial[j] - {1'b0, dv_in[j]}) : trial[j][DW-1:0];
            nq_nx[j]  = {nq_in[j][NW-2:0], ge[j]};
        end

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                rem_reg[j] <= rem_nx[j];
                nq_reg[j]  <= nq_nx[j];
                dv_reg[j]  <= dv_in[j];
            end
        end
    end

    assign quo = nq_reg[NW-1];

endmodule

// File: rtl/core/fesi_mac_lane.sv
// one weight times vertex value product lane
module fesi_mac_lane (
    input  logic              clk,
    input  logic              en,
    input  fesi_pkg::weight_t wt,
    input  fesi_pkg::value_t  val,
    output fesi_pkg::mac_t    prod
);
    import fesi_pkg::*;

    mac_t prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= mac_t'(wt) * mac_t'(val);
        end
    end

    assign prod = prod_reg;

endmodule

// File: rtl/core/fesi_merge.sv
// merge of the lane products: adder tree, rounding, saturation, zeroing on error and output register
module fesi_merge (
    input  logic                        clk,
    input  fesi_pkg::merge_en_t         en,
    input  fesi_pkg::mac_t [fesi_pkg::NV-1:0] prod,
    input  fesi_pkg::tag_t              tag,
    output fesi_pkg::value_t            interp_value,
    output logic [1:0]                  error_code,
    output logic                        last_out
);
    import fesi_pkg::*;

    localparam logic signed [SW-1:0] VMAX =
        {{(SW - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
    localparam logic signed [SW-1:0] VMIN = ~VMAX;
    localparam logic signed [SW-1:0] HALF = SW'(ONE_INT >> 1);

    logic signed [MW:0]   pair_next [3];
    logic signed [MW:0]   pair_reg  [3];
    logic signed [SW-1:0] tot_next, tot_reg;
    logic signed [SW-1:0] rnd;
    value_t               val_next, val_reg;
    tag_t                 tag_pair_reg, tag_tot_reg, tag_out_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pair_next[i] = (MW + 1)'($signed(prod[2*i])) + (MW + 1)'($signed(prod[2*i+1]));
        end
        tot_next = SW'(pair_reg[0]) + SW'(pair_reg[1]) + SW'(pair_reg[2]);

        // round to nearest, ties toward plus infinity
        rnd = (tot_reg + HALF) >>> COORD_FRAC_BITS;
        if (tag_tot_reg.err != ERR_NONE)
        begin
            val_next = '0;
        end
        else if (rnd > VMAX)
        begin
            val_next = VMAX[VALUE_WIDTH-1:0];
        end
        else if (rnd < VMIN)
        begin
            val_next = VMIN[VALUE_WIDTH-1:0];
        end
        else
        begin
            val_next = rnd[VALUE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.pair)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pair_reg[i] <= pair_next[i];
            end
            tag_pair_reg <= tag;
        end
        if (en.total)
        begin
            tot_reg     <= tot_next;
            tag_tot_reg <= tag_pair_reg;
        end
        if (en.out)
        begin
            val_reg     <= val_next;
            tag_out_reg <= tag_tot_reg;
        end
    end

    assign interp_value = val_reg;
    assign error_code   = tag_out_reg.err;
    assign last_out     = tag_out_reg.last;

endmodule
